### rtl/core/ffha_pkg.sv
// Shared types, codes and defaults for the first-fit heap allocator.
package ffha_pkg;

  localparam int ADDR_BITS     = 32;
  localparam int COUNT_BITS    = 26;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam int DEF_SEGMENT_SLOTS = 64;
  localparam int DEF_LIVE_SLOTS    = 256;
  localparam int DEF_BLOCK_BYTES   = 64;
  localparam int DEF_HEADER_BYTES  = 24;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAP_END   = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FIT  = 2'd1,
    STAT_BOUNDS  = 2'd2,
    STAT_TABLE   = 2'd3
  } status_e;

  typedef struct packed {
    logic                  opcode;
    logic [COUNT_BITS-1:0] block_count;
    logic [ADDR_BITS-1:0]  free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] granted_address;
    status_e              status;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BUILD,
    ST_DISPATCH,
    ST_A_SLOT,
    ST_A_RD,
    ST_A_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_F_LRD,
    ST_F_LCHK,
    ST_F_SRD,
    ST_F_SCHK,
    ST_F_DEC,
    ST_IN_RD,
    ST_IN_WR,
    ST_IN_PUT,
    ST_RESP
  } state_e;

endpackage

### rtl/core/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator: free-segment table, live table and request sequencer.
//
//  channel | signals                                  | beat
//  in      | in_valid_i / in_ready_o / in_req_i       | opcode, block_count, free_address
//  out     | out_valid_o / out_ready_i / out_rsp_o    | granted_address, status
//  cfg     | cfg_we_i / cfg_index_i / cfg_data_i      | heap_start (0), heap_end (1)
//
// One request at a time; in_ready_o is high only while the sequencer idles.
// Allocate searches for a free live slot (up to LIVE_SLOTS), scans segments and
// moves entries on removal; free searches live entries, scans segments and moves
// entries; all table traffic goes through one RAM port each.
// First request after a config write passes through a build state. Reset clears control only.
// A held result in the output register does not stop the next request from starting.
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int SEGMENT_SLOTS = DEF_SEGMENT_SLOTS,
  parameter int LIVE_SLOTS    = DEF_LIVE_SLOTS,
  parameter int BLOCK_BYTES   = DEF_BLOCK_BYTES,
  parameter int HEADER_BYTES  = DEF_HEADER_BYTES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  req_t                     in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rsp_t                     out_rsp_o
);

  localparam int AW     = ADDR_BITS;
  localparam int SW     = $clog2(SEGMENT_SLOTS);
  localparam int CNTW   = $clog2(SEGMENT_SLOTS + 1);
  localparam int LW     = $clog2(LIVE_SLOTS);
  localparam int NEED_W = COUNT_BITS + $clog2(BLOCK_BYTES) + 1;
  localparam int CW     = (NEED_W > AW) ? NEED_W : AW;

  state_e state_q, state_d;

  logic              op_q;
  logic [NEED_W-1:0] need_q;
  logic [AW-1:0]     addr_q, blk_q, bsize_q;
  logic [AW-1:0]     heap_start_q, heap_end_q;
  logic              heap_ready_q;
  logic [CNTW-1:0]   seg_cnt_q, idx_q, ins_q;
  logic [LW-1:0]     slot_q;
  logic [LIVE_SLOTS-1:0] live_valid_q;
  logic [2*AW-1:0]   prev_q, next_q;
  logic              has_next_q;
  logic [AW-1:0]     res_addr_q;
  status_e           res_status_q;
  rsp_t              out_q;
  logic              out_valid_q;

  logic            seg_we, live_we;
  logic [SW-1:0]   seg_waddr, seg_raddr;
  logic [2*AW-1:0] seg_wdata, seg_rdata, live_wdata, live_rdata;
  logic [LW-1:0]   live_waddr, live_raddr;

  logic [AW-1:0] rd_start, rd_size, lv_addr, lv_size;
  logic [AW-1:0] prev_start, prev_size, next_start, next_size;
  logic          build_ok, bounds_bad, fits, whole, join_prev, join_next, live_hit;
  logic [CW-1:0] leftover;

  assign rd_start   = seg_rdata[2*AW-1:AW];
  assign rd_size    = seg_rdata[AW-1:0];
  assign lv_addr    = live_rdata[2*AW-1:AW];
  assign lv_size    = live_rdata[AW-1:0];
  assign prev_start = prev_q[2*AW-1:AW];
  assign prev_size  = prev_q[AW-1:0];
  assign next_start = next_q[2*AW-1:AW];
  assign next_size  = next_q[AW-1:0];

  assign build_ok   = (heap_end_q > heap_start_q) &&
                      ((heap_end_q - heap_start_q) > AW'(HEADER_BYTES));
  assign bounds_bad = (addr_q == '0) || (addr_q > heap_end_q) || (addr_q < heap_start_q);
  assign fits       = CW'(rd_size) >= CW'(need_q);
  assign leftover   = CW'(rd_size) - CW'(need_q);
  assign whole      = leftover <= CW'(HEADER_BYTES);
  assign live_hit   = live_valid_q[slot_q] && (lv_addr == blk_q);
  assign join_prev  = (idx_q != '0) && ((prev_start + prev_size) == blk_q);
  assign join_next  = has_next_q && ((blk_q + bsize_q) == next_start);

  ffha_ram #(.WIDTH(2*AW), .DEPTH(SEGMENT_SLOTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  ffha_ram #(.WIDTH(2*AW), .DEPTH(LIVE_SLOTS)) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (live_waddr),
    .wdata_i (live_wdata),
    .raddr_i (live_raddr),
    .rdata_o (live_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = heap_ready_q ? ST_DISPATCH : ST_BUILD;
      end
      ST_BUILD: state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (op_q == OP_ALLOC) state_d = ST_A_SLOT;
        else if (bounds_bad) state_d = ST_RESP;
        else state_d = ST_F_LRD;
      end
      ST_A_SLOT: begin
        if (!live_valid_q[slot_q]) state_d = ST_A_RD;
        else if (slot_q == LW'(LIVE_SLOTS - 1)) state_d = ST_RESP;
      end
      ST_A_RD: state_d = (idx_q < seg_cnt_q) ? ST_A_CHK : ST_RESP;
      ST_A_CHK: begin
        if (!fits) state_d = ST_A_RD;
        else if (whole) state_d = ST_RM_RD;
        else state_d = ST_RESP;
      end
      ST_RM_RD: state_d = ((idx_q + 1'b1) < seg_cnt_q) ? ST_RM_WR : ST_RESP;
      ST_RM_WR: state_d = ST_RM_RD;
      ST_F_LRD: state_d = ST_F_LCHK;
      ST_F_LCHK: begin
        if (live_hit) state_d = ST_F_SRD;
        else if (slot_q == LW'(LIVE_SLOTS - 1)) state_d = ST_RESP;
        else state_d = ST_F_LRD;
      end
      ST_F_SRD: state_d = (idx_q < seg_cnt_q) ? ST_F_SCHK : ST_F_DEC;
      ST_F_SCHK: state_d = (rd_start > blk_q) ? ST_F_DEC : ST_F_SRD;
      ST_F_DEC: begin
        if (join_prev && join_next) state_d = ST_RM_RD;
        else if (join_prev || join_next) state_d = ST_RESP;
        else if (seg_cnt_q >= CNTW'(SEGMENT_SLOTS)) state_d = ST_RESP;
        else state_d = ST_IN_RD;
      end
      ST_IN_RD: state_d = (ins_q > idx_q) ? ST_IN_WR : ST_IN_PUT;
      ST_IN_WR: state_d = ST_IN_RD;
      ST_IN_PUT: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    seg_we     = 1'b0;
    seg_waddr  = idx_q[SW-1:0];
    seg_wdata  = seg_rdata;
    seg_raddr  = idx_q[SW-1:0];
    live_we    = 1'b0;
    live_waddr = slot_q;
    live_wdata = {rd_start, rd_size};
    live_raddr = slot_q;
    unique case (state_q)
      ST_BUILD: begin
        seg_we    = build_ok;
        seg_waddr = '0;
        seg_wdata = {heap_start_q, heap_end_q - heap_start_q - AW'(HEADER_BYTES)};
      end
      ST_A_CHK: begin
        live_we    = fits;
        live_wdata = {rd_start, whole ? rd_size : AW'(need_q)};
        seg_we     = fits && !whole;
        seg_wdata  = {rd_start + AW'(need_q), AW'(leftover)};
      end
      ST_RM_RD: seg_raddr = SW'(idx_q + 1'b1);
      ST_RM_WR: seg_we = 1'b1;
      ST_F_DEC: begin
        if (join_prev) begin
          seg_we    = 1'b1;
          seg_waddr = SW'(idx_q - 1'b1);
          seg_wdata = {prev_start, prev_size + bsize_q + (join_next ? next_size : '0)};
        end else if (join_next) begin
          seg_we    = 1'b1;
          seg_wdata = {blk_q, next_size + bsize_q};
        end
      end
      ST_IN_RD: seg_raddr = SW'(ins_q - 1'b1);
      ST_IN_WR: begin
        seg_we    = 1'b1;
        seg_waddr = ins_q[SW-1:0];
      end
      ST_IN_PUT: begin
        seg_we    = 1'b1;
        seg_wdata = {blk_q, bsize_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      heap_ready_q <= 1'b0;
      seg_cnt_q    <= '0;
      live_valid_q <= '0;
      out_valid_q  <= 1'b0;
      heap_start_q <= '0;
      heap_end_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        heap_ready_q <= 1'b0;
        if (cfg_index_i == CFG_HEAP_START) heap_start_q <= cfg_data_i;
        else heap_end_q <= cfg_data_i;
      end
      if (state_q == ST_RESP && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_BUILD: begin
          live_valid_q <= '0;
          heap_ready_q <= 1'b1;
          seg_cnt_q    <= build_ok ? CNTW'(1) : '0;
        end
        ST_A_CHK: if (fits) live_valid_q[slot_q] <= 1'b1;
        ST_RM_RD: if (!((idx_q + 1'b1) < seg_cnt_q)) seg_cnt_q <= seg_cnt_q - 1'b1;
        ST_F_DEC: begin
          if (join_prev || join_next || seg_cnt_q < CNTW'(SEGMENT_SLOTS)) begin
            live_valid_q[slot_q] <= 1'b0;
          end
        end
        ST_IN_PUT: seg_cnt_q <= seg_cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q   <= in_req_i.opcode;
        need_q <= NEED_W'(in_req_i.block_count) * NEED_W'(BLOCK_BYTES) + NEED_W'(HEADER_BYTES);
        addr_q <= in_req_i.free_address;
        blk_q  <= in_req_i.free_address - AW'(HEADER_BYTES);
      end
      ST_DISPATCH: begin
        slot_q       <= '0;
        idx_q        <= '0;
        res_addr_q   <= '0;
        res_status_q <= (op_q == OP_FREE && bounds_bad) ? STAT_BOUNDS : STAT_OK;
      end
      ST_A_SLOT: begin
        if (live_valid_q[slot_q]) begin
          if (slot_q == LW'(LIVE_SLOTS - 1)) res_status_q <= STAT_TABLE;
          else slot_q <= slot_q + 1'b1;
        end
      end
      ST_A_RD: if (!(idx_q < seg_cnt_q)) res_status_q <= STAT_NO_FIT;
      ST_A_CHK: begin
        if (fits) res_addr_q <= rd_start + AW'(HEADER_BYTES);
        else idx_q <= idx_q + 1'b1;
      end
      ST_RM_WR: idx_q <= idx_q + 1'b1;
      ST_F_LCHK: begin
        if (live_hit) begin
          bsize_q <= lv_size;
          idx_q   <= '0;
        end else if (slot_q == LW'(LIVE_SLOTS - 1)) begin
          res_status_q <= STAT_TABLE;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      ST_F_SRD: if (!(idx_q < seg_cnt_q)) has_next_q <= 1'b0;
      ST_F_SCHK: begin
        if (rd_start > blk_q) begin
          next_q     <= seg_rdata;
          has_next_q <= 1'b1;
        end else begin
          prev_q <= seg_rdata;
          idx_q  <= idx_q + 1'b1;
        end
      end
      ST_F_DEC: begin
        ins_q <= seg_cnt_q;
        if (!join_prev && !join_next && seg_cnt_q >= CNTW'(SEGMENT_SLOTS)) begin
          res_status_q <= STAT_TABLE;
        end
      end
      ST_IN_WR: ins_q <= ins_q - 1'b1;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.granted_address <= (res_status_q == STAT_OK) ? res_addr_q : '0;
          out_q.status          <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_seg_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= CNTW'(SEGMENT_SLOTS)) else $error("segment count overflow");
  a_build_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD && !cfg_we_i) |=> heap_ready_q) else $error("heap not ready after build");
  a_alloc_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_CHK && live_we) |-> !live_valid_q[slot_q])
    else $error("live slot overwritten");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IN_PUT) |-> (seg_cnt_q < CNTW'(SEGMENT_SLOTS)))
    else $error("insert into full segment table");
`endif

endmodule
